// File: hdl/smpq_pkg.sv
package smpq_pkg;

   localparam int DefaultCapacity = 16;
   localparam int KeyWidth = 32;
   localparam int CountOutWidth = 5;

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_PEEK  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_NAN   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_APPLY = 2'd1,
      ST_REPLY = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POP   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [KeyWidth-1:0] key_bits;
   } req_type;

   typedef struct packed {
      logic [KeyWidth-1:0]      top_bits;
      logic [CountOutWidth-1:0] entry_count;
      logic                     is_empty;
      logic                     is_full;
      logic [1:0]               status;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_nan;
      logic is_empty;
      logic is_full;
   } stat_type;

   // Maps non-NaN float bits to an unsigned code ordered like the reals.
   function automatic logic [KeyWidth-1:0] order_value(input logic [KeyWidth-1:0] b);
      logic [KeyWidth-1:0] v;
      v = b;
      if (v == {1'b1, {(KeyWidth-1){1'b0}}}) begin
         v = '0;
      end
      if (v[KeyWidth-1]) begin
         return ~v;
      end
      return v | {1'b1, {(KeyWidth-1){1'b0}}};
   endfunction

endpackage

// File: hdl/sorted_min_priority_queue.sv
// Channel   Ports            Handshake
// request   req_word         accepted when start && !busy
// response  rsp_word         rsp_strobe high for one cycle, no back pressure
//
// Each word passes through capture, apply and respond; busy stays high
// until the response cycle ends. The shift cells compare all keys at once,
// so the time does not depend on the fill. Synchronous reset empties the
// queue. The receiver cannot stall the response.
module sorted_min_priority_queue
   import smpq_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_word,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   cmd_type  cmd;
   stat_type stat;
   logic [1:0] status;

   smpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_word.func),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_status (status)
   );

   smpq_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .key_bits    (req_word.key_bits),
      .cmd         (cmd),
      .stat        (stat),
      .top_bits    (rsp_word.top_bits),
      .entry_count (rsp_word.entry_count)
   );

   assign rsp_word.is_empty = stat.is_empty;
   assign rsp_word.is_full  = stat.is_full;
   assign rsp_word.status   = status;

endmodule

// File: hdl/smpq_ctrl.sv
module smpq_ctrl
   import smpq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] func,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe,
   output logic [1:0] rsp_status
);

   state_type  state_ff, state_in;
   func_type   func_ff, func_in;
   status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         func_ff   <= FUNC_PEEK;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         func_ff   <= func_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      status_in  = status_ff;
      cmd.load   = 1'b0;
      cmd.op     = OP_NONE;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               func_in  = func_type'(func);
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            status_in = STATUS_OK;
            case (func_ff)
               FUNC_PUSH: begin
                  if (stat.is_nan) begin
                     status_in = STATUS_NAN;
                  end else if (stat.is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     cmd.op = OP_PUSH;
                  end
               end
               FUNC_POP: begin
                  if (stat.is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cmd.op = OP_POP;
                  end
               end
               FUNC_PEEK: begin
                  if (stat.is_empty) begin
                     status_in = STATUS_EMPTY;
                  end
               end
               default: cmd.op = OP_CLEAR;
            endcase
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_status = status_ff;

endmodule

// File: hdl/smpq_datapath.sv
module smpq_datapath
   import smpq_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [KeyWidth-1:0]      key_bits,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic [KeyWidth-1:0]      top_bits,
   output logic [CountOutWidth-1:0] entry_count
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic [KeyWidth-1:0] key_ff;
   logic [KeyWidth-1:0] cell_ff [CAPACITY];
   logic [CntW-1:0]     count_ff, count_in;
   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] geq;
   logic [CAPACITY-1:0] gt;
   logic [CAPACITY-1:0] ins;
   logic                any_gt;
   logic                any_ins;
   logic [KeyWidth-1:0] kval;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key_bits;
      end
   end

   assign kval = order_value(key_ff);

   // A key that ties the head goes first; otherwise a key that is not below the tail
   // goes last, so only when some stored key is strictly greater does it go in front
   // of the leftmost key that is >= it.
   assign any_gt  = |gt;
   assign any_ins = |ins;

   // Each cell compares the new key with its own content in parallel.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = (CntW'(i) < count_ff);
      assign geq[i] = occ[i] && (order_value(cell_ff[i]) >= kval);
      assign gt[i]  = occ[i] && (order_value(cell_ff[i]) > kval);
      assign ins[i] = geq[i] && (geq[0] || any_gt);

      always_ff @(posedge clock) begin
         if (cmd.op == OP_PUSH) begin
            if (ins[i]) begin
               if (i == 0) begin
                  cell_ff[i] <= key_ff;
               end else if (!ins[(i == 0) ? 0 : i-1] && occ[(i == 0) ? 0 : i-1]) begin
                  cell_ff[i] <= key_ff;
               end else begin
                  cell_ff[i] <= cell_ff[(i == 0) ? 0 : i-1];
               end
            end else if (CntW'(i) == count_ff) begin
               // The first free cell takes the shifted tail, or the key when appending.
               cell_ff[i] <= any_ins ? cell_ff[(i == 0) ? 0 : i-1] : key_ff;
            end
         end else if (cmd.op == OP_POP) begin
            if (i < CAPACITY - 1) begin
               cell_ff[i] <= cell_ff[(i < CAPACITY - 1) ? i+1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         OP_PUSH:  count_in = count_ff + CntW'(1);
         OP_POP:   count_in = count_ff - CntW'(1);
         OP_CLEAR: count_in = '0;
         default:  count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.is_nan   = (key_ff[30:23] == 8'hFF) && (key_ff[22:0] != '0);
   assign stat.is_empty = (count_ff == '0);
   assign stat.is_full  = (count_ff == CntW'(CAPACITY));

   assign top_bits    = stat.is_empty ? '0 : cell_ff[0];
   assign entry_count = CountOutWidth'(count_ff);

endmodule

// File: hdl/smpq_checker.sv
module smpq_checker
   import smpq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_word
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word did not raise busy");

   a_strobe_timing: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe) else $error("response not on time");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.is_empty) |-> (rsp_word.top_bits == '0 &&
       rsp_word.entry_count == '0)) else $error("empty queue shows data");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.is_empty && rsp_word.is_full))
      else $error("empty and full together");

endmodule

bind sorted_min_priority_queue smpq_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
);
